@@ rtl/core/salc_pkg.sv @@
package salc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WRITE
  } state_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS       = 2'd2;

  localparam logic [1:0] KIND_FETCH  = 2'd0;
  localparam logic [1:0] KIND_ACCESS = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  localparam logic [1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [1:0] OUTCOME_EVICT = 2'd2;

  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

endpackage

@@ rtl/core/salc_ram.sv @@
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/set_assoc_lru_cache_tags.sv @@
// Tag and true-LRU replacement engine of a set-associative cache. Pulse start
// with kind and address while busy is low. A load/store or modify returns one
// result word on the done strobe after acceptance, through lookup and
// write-back, with busy high in between; a fetch or spare kind is dropped at
// the accept edge and gives no word. The result is shown for one cycle only,
// there is no back-pressure. Each set is one row of the set memory (valid, tag
// and age rank of every way), read on accept and written back once; rows never
// written since reset read as empty, so no clearing pass is needed.
// Configuration must be written only while idle.
module set_assoc_lru_cache_tags
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             kind,
  input  logic [ADDR_WIDTH-1:0]  address,
  output logic                   done,
  output logic [1:0]             outcome,
  output logic                   second_hit,
  output logic [31:0]            hit_total,
  output logic [31:0]            miss_total,
  output logic [31:0]            eviction_total,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
  localparam int ENTRY_W  = 1 + ADDR_WIDTH + RANK_W;
  localparam int ROW_W    = MAX_WAYS * ENTRY_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
  localparam logic [RANK_W:0]   RANK_NONE = (RANK_W + 1)'(MAX_WAYS);

  state_t state, state_next;

  logic [2:0] set_bits_cfg;
  logic [4:0] block_bits_cfg;
  logic [3:0] ways_cfg;

  logic [MAX_SET_BITS-1:0] set_q;
  logic [ADDR_WIDTH-1:0]   tag_q;
  logic                    modify_q;
  logic [WAY_W-1:0]        way_q;
  logic [1:0]              outcome_q;
  logic [NUM_SETS-1:0]     row_valid;

  logic                    accept;
  logic                    ram_re;
  logic                    ram_we;
  logic [ROW_W-1:0]        rd_row;
  logic [ROW_W-1:0]        wr_row;

  logic [ADDR_WIDTH-1:0]   shifted;
  logic [SB_W-1:0]         sb;
  logic [MAX_SET_BITS-1:0] set_mask;
  logic [MAX_SET_BITS-1:0] set_in;
  logic [ADDR_WIDTH-1:0]   tag_in;
  logic [CNT_W-1:0]        nw;
  logic [MAX_WAYS-1:0]     in_use;

  logic                    way_valid [MAX_WAYS];
  logic [ADDR_WIDTH-1:0]   way_tag   [MAX_WAYS];
  logic [RANK_W-1:0]       way_rank  [MAX_WAYS];

  logic                    hit_found;
  logic [WAY_W-1:0]        hit_way;
  logic                    free_found;
  logic [WAY_W-1:0]        free_way;
  logic [WAY_W-1:0]        victim;
  logic [RANK_W-1:0]       oldest;
  logic [RANK_W:0]         old_rank;

  logic [1:0]              hit_inc;
  logic [32:0]             hit_sum;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits_cfg   <= 3'd1;
      block_bits_cfg <= 5'd1;
      ways_cfg       <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SET_BITS:   set_bits_cfg   <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits_cfg <= cfg_data;
        REG_WAYS:       ways_cfg       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    shifted = address >> block_bits_cfg;
    if (32'(set_bits_cfg) > 32'(MAX_SET_BITS)) begin
      sb = SB_W'(MAX_SET_BITS);
    end else begin
      sb = SB_W'(set_bits_cfg);
    end
    for (int j = 0; j < MAX_SET_BITS; j++) begin
      set_mask[j] = 32'(j) < 32'(sb);
    end
    set_in = shifted[MAX_SET_BITS-1:0] & set_mask;
    tag_in = shifted >> sb;
  end

  always_comb begin
    if (ways_cfg == 4'd0) begin
      nw = CNT_W'(1);
    end else if (32'(ways_cfg) > 32'(MAX_WAYS)) begin
      nw = CNT_W'(MAX_WAYS);
    end else begin
      nw = CNT_W'(ways_cfg);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = 32'(i) < 32'(nw);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    accept     = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && (kind == KIND_ACCESS || kind == KIND_MODIFY)) begin
          accept     = 1'b1;
          ram_re     = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_set_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(set_q),
    .wdata(wr_row),
    .re   (ram_re),
    .raddr(set_in),
    .rdata(rd_row)
  );

  // row unpack; a row never written reads as empty
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      way_tag[i] = rd_row[i*ENTRY_W+RANK_W +: ADDR_WIDTH];
      if (row_valid[set_q]) begin
        way_valid[i] = rd_row[i*ENTRY_W+ENTRY_W-1];
        way_rank[i]  = rd_row[i*ENTRY_W +: RANK_W];
      end else begin
        way_valid[i] = 1'b0;
        way_rank[i]  = '0;
      end
    end
  end

  // lookup: lowest matching way, lowest free way, oldest valid way
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && way_valid[i] && way_tag[i] == tag_q) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      if (in_use[i] && !way_valid[i]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(i);
      end
    end
    victim = '0;
    oldest = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && way_rank[i] > oldest) begin
        oldest = way_rank[i];
        victim = WAY_W'(i);
      end
    end
  end

  // touch: ways younger than the touched one age by one
  always_comb begin
    if (outcome_q == OUTCOME_FILL) begin
      old_rank = RANK_NONE;
    end else begin
      old_rank = {1'b0, way_rank[way_q]};
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == way_q) begin
        wr_row[i*ENTRY_W +: ENTRY_W] = {1'b1, tag_q, {RANK_W{1'b0}}};
      end else if (in_use[i] && way_valid[i] && {1'b0, way_rank[i]} < old_rank &&
                   way_rank[i] < RANK_MAX) begin
        wr_row[i*ENTRY_W +: ENTRY_W] = {1'b1, way_tag[i], way_rank[i] + RANK_W'(1)};
      end else begin
        wr_row[i*ENTRY_W +: ENTRY_W] = {way_valid[i], way_tag[i], way_rank[i]};
      end
    end
  end

  // a modify's store always hits the way just touched and changes no rank
  assign hit_inc = 2'((outcome_q == OUTCOME_HIT) ? 1 : 0) + 2'(modify_q);
  assign hit_sum = {1'b0, hit_total} + 33'(hit_inc);

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q    <= set_in;
      tag_q    <= tag_in;
      modify_q <= (kind == KIND_MODIFY);
    end
    if (state == ST_LOOK) begin
      if (hit_found) begin
        way_q     <= hit_way;
        outcome_q <= OUTCOME_HIT;
      end else if (free_found) begin
        way_q     <= free_way;
        outcome_q <= OUTCOME_FILL;
      end else begin
        way_q     <= victim;
        outcome_q <= OUTCOME_EVICT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid      <= '0;
      done           <= 1'b0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else begin
      done <= (state == ST_WRITE);
      if (state == ST_WRITE) begin
        row_valid[set_q] <= 1'b1;
        hit_total <= hit_sum[32] ? TOTAL_MAX : hit_sum[31:0];
        if (outcome_q != OUTCOME_HIT && miss_total != TOTAL_MAX) begin
          miss_total <= miss_total + 32'd1;
        end
        if (outcome_q == OUTCOME_EVICT && eviction_total != TOTAL_MAX) begin
          eviction_total <= eviction_total + 32'd1;
        end
      end
    end
  end

  assign outcome    = outcome_q;
  assign second_hit = modify_q;

endmodule

@@ rtl/core/salc_checker.sv @@
module salc_checker
  import salc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind,
  input logic       done,
  input logic [1:0] outcome
);

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == KIND_ACCESS || kind == KIND_MODIFY) |-> ##3 done)
    else $error("no result three cycles after a data access");

  a_fetch_dropped: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !(kind == KIND_ACCESS || kind == KIND_MODIFY) |=> !busy)
    else $error("ignored access made the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(done))
    else $error("result word while busy or strobe longer than one cycle");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (outcome == OUTCOME_HIT || outcome == OUTCOME_FILL ||
              outcome == OUTCOME_EVICT))
    else $error("bad outcome code");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (.*);

@@ tb/tb_set_assoc_lru_cache_tags.sv @@
module tb_set_assoc_lru_cache_tags;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int SET_CAP         = 64;
  localparam int WAY_CAP         = 8;
  localparam int SET_BITS_CAP    = 6;
  localparam int ADDR_W          = 48;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int SETTLE_CYCLES   = 4;
  localparam int STALL_LIMIT     = 2000;
  localparam int PHASES          = 16;
  localparam int WORDS_PER_PHASE = 50;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        second_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } access_word_t;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_CHECKED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          op;
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  addr;
    logic [2:0]         set_bits;
    logic [4:0]         block_bits;
    logic [3:0]         ways;
    access_word_t       want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             kind = '0;
  logic [ADDR_W-1:0]      address = '0;
  logic                   done;
  logic [1:0]             outcome;
  logic                   second_hit;
  logic [31:0]            hit_total;
  logic [31:0]            miss_total;
  logic [31:0]            eviction_total;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  set_assoc_lru_cache_tags dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .address       (address),
    .done          (done),
    .outcome       (outcome),
    .second_hit    (second_hit),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .eviction_total(eviction_total),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cache tag state as the block should hold it
  logic              way_valid [SET_CAP][WAY_CAP];
  logic [ADDR_W-1:0] way_tag   [SET_CAP][WAY_CAP];
  logic [2:0]        way_age   [SET_CAP][WAY_CAP];
  logic [31:0]       hit_count;
  logic [31:0]       miss_count;
  logic [31:0]       evict_count;
  logic [2:0]        cur_set_bits;
  logic [4:0]        cur_block_bits;
  logic [3:0]        cur_ways;

  access_word_t pending_words[$];
  plan_row_t    plan[$];
  int           error_count = 0;
  int           stall_cycles = 0;

  function automatic logic [31:0] count_up(logic [31:0] c);
    return (c == TOTAL_MAX) ? c : c + 32'd1;
  endfunction

  // invalid way counts as oldest; younger valid ways age by one
  function automatic void make_recent(int s, int w, int nw);
    int prior;
    prior = way_valid[s][w] ? int'(way_age[s][w]) : WAY_CAP;
    for (int i = 0; i < nw; i++) begin
      if (i != w && way_valid[s][i] && int'(way_age[s][i]) < prior &&
          int'(way_age[s][i]) < WAY_CAP - 1) begin
        way_age[s][i] = way_age[s][i] + 3'd1;
      end
    end
    way_age[s][w] = '0;
  endfunction

  function automatic logic [1:0] touch_line(int s, logic [ADDR_W-1:0] tag, int nw);
    int victim;
    int eldest;
    for (int i = 0; i < nw; i++) begin
      if (way_valid[s][i] && way_tag[s][i] == tag) begin
        make_recent(s, i, nw);
        hit_count = count_up(hit_count);
        return OUTCOME_HIT;
      end
    end
    miss_count = count_up(miss_count);
    for (int i = 0; i < nw; i++) begin
      if (!way_valid[s][i]) begin
        make_recent(s, i, nw);
        way_valid[s][i] = 1'b1;
        way_tag[s][i] = tag;
        return OUTCOME_FILL;
      end
    end
    victim = 0;
    eldest = 0;
    for (int i = 0; i < nw; i++) begin
      if (int'(way_age[s][i]) > eldest) begin
        eldest = int'(way_age[s][i]);
        victim = i;
      end
    end
    make_recent(s, victim, nw);
    way_tag[s][victim] = tag;
    evict_count = count_up(evict_count);
    return OUTCOME_EVICT;
  endfunction

  function automatic bit predict_access(logic [1:0] k, logic [ADDR_W-1:0] a,
                                        output access_word_t w);
    int sb;
    int nw;
    int s;
    logic [ADDR_W-1:0] line_addr;
    logic [ADDR_W-1:0] tag;
    w = '0;
    if (k != KIND_ACCESS && k != KIND_MODIFY) return 1'b0;
    sb = (cur_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(cur_set_bits);
    nw = (cur_ways == 0) ? 1 : ((cur_ways > WAY_CAP) ? WAY_CAP : int'(cur_ways));
    line_addr = a >> cur_block_bits;
    s = int'(line_addr & ((48'd1 << sb) - 48'd1));
    tag = line_addr >> sb;
    w.outcome = touch_line(s, tag, nw);
    if (k == KIND_MODIFY) w.second_hit = (touch_line(s, tag, nw) == OUTCOME_HIT);
    w.hits = hit_count;
    w.misses = miss_count;
    w.evictions = evict_count;
    return 1'b1;
  endfunction

  function automatic void add_word(logic [1:0] k, logic [ADDR_W-1:0] a);
    plan_row_t r;
    r = '0;
    r.op = ROW_WORD;
    r.kind = k;
    r.addr = a;
    plan.push_back(r);
  endfunction

  function automatic void add_checked(logic [1:0] k, logic [ADDR_W-1:0] a, logic [1:0] o,
                                      logic sec, int h, int m, int e);
    plan_row_t r;
    r = '0;
    r.op = ROW_CHECKED;
    r.kind = k;
    r.addr = a;
    r.want.outcome = o;
    r.want.second_hit = sec;
    r.want.hits = h;
    r.want.misses = m;
    r.want.evictions = e;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(logic [2:0] sb, logic [4:0] bb, logic [3:0] w);
    plan_row_t r;
    r = '0;
    r.op = ROW_CFG;
    r.set_bits = sb;
    r.block_bits = bb;
    r.ways = w;
    plan.push_back(r);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_word(logic [1:0] k, logic [ADDR_W-1:0] a, bit typed,
                           access_word_t typed_word);
    access_word_t w;
    start <= 1'b1;
    kind <= k;
    address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_access(k, a, w)) pending_words.push_back(typed ? typed_word : w);
  endtask

  // stop sending, wait for every word, then let a dropped fetch clear
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_words.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [2:0] sb, logic [4:0] bb, logic [3:0] w);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_SET_BITS;
    cfg_data <= CFG_DATA_W'(sb);
    @(posedge clk);
    cfg_index <= REG_BLOCK_BITS;
    cfg_data <= bb;
    @(posedge clk);
    cfg_index <= REG_WAYS;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_set_bits = sb;
    cur_block_bits = bb;
    cur_ways = w;
  endtask

  always @(posedge clk) begin
    access_word_t want;
    if (!rst) begin
      if (done) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word, outcome %0d", outcome));
        end else begin
          want = pending_words.pop_front();
          if (outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, want %0d", outcome, want.outcome));
          if (second_hit !== want.second_hit)
            report_mismatch($sformatf("second_hit %0d, want %0d", second_hit,
                                      want.second_hit));
          if (hit_total !== want.hits)
            report_mismatch($sformatf("hit_total %0d, want %0d", hit_total, want.hits));
          if (miss_total !== want.misses)
            report_mismatch($sformatf("miss_total %0d, want %0d", miss_total, want.misses));
          if (eviction_total !== want.evictions)
            report_mismatch($sformatf("eviction_total %0d, want %0d", eviction_total,
                                      want.evictions));
        end
      end
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_set_assoc_lru_cache_tags: FAIL");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t         row;
    int                idle_pct;
    int                counted;
    int                pick;
    logic [1:0]        k;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] offset_mask;
    logic [ADDR_W-1:0] pool[$];

    for (int s = 0; s < SET_CAP; s++) begin
      for (int w = 0; w < WAY_CAP; w++) begin
        way_valid[s][w] = 1'b0;
        way_tag[s][w] = '0;
        way_age[s][w] = '0;
      end
    end
    hit_count = '0;
    miss_count = '0;
    evict_count = '0;
    cur_set_bits = 3'd1;
    cur_block_bits = 5'd1;
    cur_ways = 4'd1;

    // after reset: two sets, one way, one offset bit
    add_word(KIND_FETCH, '0);
    add_word(KIND_SPARE, '0);
    add_checked(KIND_ACCESS, '0, OUTCOME_FILL, 1'b0, 0, 1, 0);
    add_checked(KIND_ACCESS, '0, OUTCOME_HIT, 1'b0, 1, 1, 0);
    add_checked(KIND_MODIFY, '1, OUTCOME_FILL, 1'b1, 2, 2, 0);
    add_checked(KIND_ACCESS, 48'd4, OUTCOME_EVICT, 1'b0, 2, 3, 1);
    add_checked(KIND_MODIFY, '0, OUTCOME_EVICT, 1'b1, 3, 4, 2);
    // single set, three ways: fills, hit, LRU victim
    add_cfg(3'd0, 5'd0, 4'd3);
    add_word(KIND_ACCESS, 48'd1);
    add_word(KIND_ACCESS, 48'd2);
    add_word(KIND_ACCESS, 48'd3);
    add_word(KIND_ACCESS, 48'd1);
    add_word(KIND_ACCESS, 48'd4);
    add_word(KIND_MODIFY, 48'd2);
    add_word(KIND_ACCESS, 48'd3);
    // saturated set bits and ways, widest offset
    add_cfg(3'd7, 5'd31, 4'd15);
    add_word(KIND_ACCESS, '1);
    add_word(KIND_MODIFY, '0);
    add_word(KIND_ACCESS, 48'h8000_0000_0000);
    // zero ways acts as one
    add_cfg(3'd6, 5'd16, 4'd0);
    add_word(KIND_ACCESS, 48'h0000_0001_0000);
    add_word(KIND_ACCESS, 48'h0000_0041_0000);
    add_word(KIND_MODIFY, 48'hFFFF_0000_0000);
    // fewer ways than filled: ties on age
    add_cfg(3'd0, 5'd0, 4'd2);
    add_word(KIND_ACCESS, 48'd5);
    add_word(KIND_ACCESS, 48'd6);
    add_word(KIND_ACCESS, 48'd1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      case (row.op)
        ROW_CFG:     set_config(row.set_bits, row.block_bits, row.ways);
        ROW_CHECKED: send_word(row.kind, row.addr, 1'b1, row.want);
        default:     send_word(row.kind, row.addr, 1'b0, row.want);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(3'($urandom_range(0, 7)),
                 ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                               5'($urandom_range(0, 6)),
                 4'($urandom_range(0, 15)));
      idle_pct = (ph < PHASES / 3) ? 20 : ((ph < 2 * PHASES / 3) ? 45 : 0);
      pool.delete();
      repeat ($urandom_range(3, 12)) pool.push_back(ADDR_W'({$urandom, $urandom}));
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pick = $urandom_range(0, 19);
        k = (pick == 0) ? KIND_FETCH : (pick == 1) ? KIND_SPARE :
            (pick < 11) ? KIND_ACCESS : KIND_MODIFY;
        offset_mask = (48'd1 << cur_block_bits) - 48'd1;
        if ($urandom_range(0, 3) == 0) a = ADDR_W'({$urandom, $urandom});
        else a = pool[$urandom_range(0, pool.size() - 1)] ^
                 (ADDR_W'({$urandom, $urandom}) & offset_mask);
        send_word(k, a, 1'b0, '0);
        if (k == KIND_ACCESS || k == KIND_MODIFY) counted++;
        if (ph == 4 && counted == WORDS_PER_PHASE / 2) settle();
      end
    end

    settle();
    if (error_count == 0) begin
      $display("tb_set_assoc_lru_cache_tags: PASS");
    end else begin
      $display("tb_set_assoc_lru_cache_tags: FAIL");
    end
    $finish;
  end

endmodule
